### sv/twld_pkg.sv
// twld_pkg: shared constants, types and state codes for the window level detector
// no dependencies

package twld_pkg;

    localparam int SAMPLE_FIFO_DEPTH_D = 512;
    localparam int LEVEL_FIFO_DEPTH_D  = 512;

    localparam logic [2:0] REG_MAX_AMPLITUDE  = 3'd0;
    localparam logic [2:0] REG_SHORT_WINDOW   = 3'd1;
    localparam logic [2:0] REG_SHORT_HOP      = 3'd2;
    localparam logic [2:0] REG_LONG_WINDOW    = 3'd3;
    localparam logic [2:0] REG_LONG_HOP       = 3'd4;
    localparam logic [2:0] REG_CRITICAL_LEVEL = 3'd5;
    localparam logic [2:0] REG_AUTO_MODE      = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SSUM,
        ST_SDIV,
        ST_SPUSH,
        ST_LSUM,
        ST_LDIV,
        ST_OUT
    } t_state;

    // request to the divider and its answer
    typedef struct packed {
        logic        start;
        logic [26:0] dividend;
        logic [8:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [26:0] quotient;
    } t_div_rsp;

endpackage

### sv/twld_div.sv
// twld_div: restoring divider, one quotient bit per cycle
// depends on twld_pkg

module twld_div
    import twld_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [26:0] r_quo, n_quo;
    logic [9:0]  r_rem, n_rem;
    logic [8:0]  r_dvs;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [9:0]  w_trial;

    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[8:0], r_quo[26]};
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[25:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[25:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd26) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### sv/two_stage_window_level_detector.sv
// two_stage_window_level_detector: top level, fifo memories and sequencer
// depends on twld_pkg and twld_div

// One magnitude is taken per item. Items that do not close a short hop are
// accepted without leaving the idle state. An item that closes a short hop
// with a full enough sample fifo is summed one memory read per cycle over
// short_window entries, divided by a bit-serial divider, pushed to the level
// fifo and, when a long hop closes too, the level fifo is summed over
// long_window entries and divided again. Each summing pass uses the single
// read port of its fifo memory, and both divisions share one divider. The
// result register holds one item; input is stalled while work or an
// undelivered result is pending. The fifo memories have no reset; only
// written entries are summed.

module two_stage_window_level_detector
    import twld_pkg::*;
#(
    parameter int SAMPLE_FIFO_DEPTH = SAMPLE_FIFO_DEPTH_D,
    parameter int LEVEL_FIFO_DEPTH  = LEVEL_FIFO_DEPTH_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_magnitude,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_short_level,
    output logic        o_long_valid,
    output logic [15:0] o_long_level,
    output logic        o_speech_active,
    output logic        o_stop_event,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SAW = $clog2(SAMPLE_FIFO_DEPTH);
    localparam int LAW = $clog2(LEVEL_FIFO_DEPTH);
    localparam int SFW = $clog2(SAMPLE_FIFO_DEPTH + 1);
    localparam int LFW = $clog2(LEVEL_FIFO_DEPTH + 1);

    // configuration registers
    logic [15:0] r_max_amp, r_crit;
    logic [8:0]  r_sw, r_sh, r_lw, r_lh;
    logic        r_auto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_amp <= 16'd32767;
            r_sw      <= 9'd128;
            r_sh      <= 9'd64;
            r_lw      <= 9'd100;
            r_lh      <= 9'd40;
            r_crit    <= 16'd5000;
            r_auto    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_AMPLITUDE:  r_max_amp <= i_cfg_data;
                REG_SHORT_WINDOW:   r_sw      <= i_cfg_data[8:0];
                REG_SHORT_HOP:      r_sh      <= i_cfg_data[8:0];
                REG_LONG_WINDOW:    r_lw      <= i_cfg_data[8:0];
                REG_LONG_HOP:       r_lh      <= i_cfg_data[8:0];
                REG_CRITICAL_LEVEL: r_crit    <= i_cfg_data;
                REG_AUTO_MODE:      r_auto    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero windows behave as one
    logic [8:0] w_sw, w_lw;
    assign w_sw = (r_sw == 9'd0) ? 9'd1 : r_sw;
    assign w_lw = (r_lw == 9'd0) ? 9'd1 : r_lw;

    // memories
    logic [15:0] r_smem [SAMPLE_FIFO_DEPTH];
    logic [15:0] r_lmem [LEVEL_FIFO_DEPTH];
    logic [15:0] r_srd, r_lrd;
    logic        s_we, l_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [LAW-1:0] l_waddr, l_raddr;
    logic [15:0] l_wdata;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_smem[s_waddr] <= i_magnitude;
        end
        r_srd <= r_smem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (l_we) begin
            r_lmem[l_waddr] <= l_wdata;
        end
        r_lrd <= r_lmem[l_raddr];
    end

    // sequencer state
    t_state r_state, n_state;
    logic [SFW-1:0] r_sfill, n_sfill;
    logic [SAW-1:0] r_shead, n_shead;
    logic [LFW-1:0] r_lfill, n_lfill;
    logic [LAW-1:0] r_lhead, n_lhead;
    logic [8:0]  r_shc, n_shc, r_lhc, n_lhc;
    logic        r_act, n_act;
    logic [8:0]  r_idx, n_idx;
    logic        r_rdv, n_rdv;
    logic [24:0] r_sum, n_sum;
    logic [15:0] r_lvl, n_lvl;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_oshort, n_oshort, r_olong, n_olong;
    logic        r_olv, n_olv, r_ostop, n_ostop;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    twld_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    logic w_accept;
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE) || (r_ovalid && i_stall);

    // helpers for address wrap
    function automatic logic [SAW-1:0] s_wrap(input logic [SAW:0] a);
        logic [SAW:0] t;
        t = (a >= (SAW+1)'(SAMPLE_FIFO_DEPTH)) ? a - (SAW+1)'(SAMPLE_FIFO_DEPTH) : a;
        return t[SAW-1:0];
    endfunction

    function automatic logic [LAW-1:0] l_wrap(input logic [LAW:0] a);
        logic [LAW:0] t;
        t = (a >= (LAW+1)'(LEVEL_FIFO_DEPTH)) ? a - (LAW+1)'(LEVEL_FIFO_DEPTH) : a;
        return t[LAW-1:0];
    endfunction

    logic [8:0]  w_shc_inc, w_lhc_inc;
    logic [SFW:0] w_spop;
    logic [LFW:0] w_lpop;
    logic [26:0] w_q;
    logic [15:0] w_qclamp;

    assign w_shc_inc = r_shc + 9'd1;
    assign w_lhc_inc = r_lhc + 9'd1;
    assign w_q       = w_div_rsp.quotient;
    assign w_qclamp  = (w_q > {11'd0, r_max_amp}) ? r_max_amp : w_q[15:0];

    always_comb begin
        n_state  = r_state;
        n_sfill  = r_sfill;
        n_shead  = r_shead;
        n_lfill  = r_lfill;
        n_lhead  = r_lhead;
        n_shc    = r_shc;
        n_lhc    = r_lhc;
        n_act    = r_act;
        n_idx    = r_idx;
        n_rdv    = 1'b0;
        n_sum    = r_sum;
        n_lvl    = r_lvl;
        n_ovalid = r_ovalid;
        n_oshort = r_oshort;
        n_olong  = r_olong;
        n_olv    = r_olv;
        n_ostop  = r_ostop;
        s_we     = 1'b0;
        l_we     = 1'b0;
        s_waddr  = r_shead;
        l_waddr  = r_lhead;
        l_wdata  = r_lvl;
        s_raddr  = s_wrap({1'b0, r_shead} + (SAW+1)'(r_idx));
        l_raddr  = l_wrap({1'b0, r_lhead} + (LAW+1)'(r_idx));
        w_div_req = '0;
        w_spop   = '0;
        w_lpop   = '0;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    s_we = 1'b1;
                    if (r_sfill >= SFW'(SAMPLE_FIFO_DEPTH)) begin
                        s_waddr = r_shead;
                        n_shead = s_wrap({1'b0, r_shead} + (SAW+1)'(1));
                    end else begin
                        s_waddr = s_wrap({1'b0, r_shead} + (SAW+1)'(r_sfill));
                        n_sfill = r_sfill + SFW'(1);
                    end
                    if (w_shc_inc >= r_sh) begin
                        n_shc = 9'd0;
                        if ({1'b0, n_sfill} >= (SFW+1)'(w_sw)) begin
                            n_state = ST_SSUM;
                            n_idx   = 9'd0;
                            n_sum   = '0;
                        end
                    end else begin
                        n_shc = w_shc_inc;
                    end
                end
            end
            ST_SSUM: begin
                // one read issued per cycle, its registered data is added in the next cycle
                if (r_rdv) begin
                    n_sum = r_sum + 25'(r_srd);
                end
                if (r_idx < w_sw) begin
                    n_rdv = 1'b1;
                    n_idx = r_idx + 9'd1;
                end else if (!r_rdv) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = 27'(r_sum) * 27'd3;
                    w_div_req.divisor  = w_sw;
                    w_spop = ((SFW+1)'(r_sh) > (SFW+1)'(r_sfill)) ?
                             (SFW+1)'(r_sfill) : (SFW+1)'(r_sh);
                    n_shead = s_wrap({1'b0, r_shead} + (SAW+1)'(w_spop));
                    n_sfill = r_sfill - w_spop[SFW-1:0];
                    n_state = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (w_div_rsp.done) begin
                    n_lvl   = w_qclamp;
                    n_state = ST_SPUSH;
                end
            end
            ST_SPUSH: begin
                l_we     = 1'b1;
                n_oshort = r_lvl;
                n_olv    = 1'b0;
                n_olong  = 16'd0;
                n_ostop  = 1'b0;
                if (r_lfill >= LFW'(LEVEL_FIFO_DEPTH)) begin
                    l_waddr = r_lhead;
                    n_lhead = l_wrap({1'b0, r_lhead} + (LAW+1)'(1));
                end else begin
                    l_waddr = l_wrap({1'b0, r_lhead} + (LAW+1)'(r_lfill));
                    n_lfill = r_lfill + LFW'(1);
                end
                n_state = ST_OUT;
                if (w_lhc_inc >= r_lh) begin
                    n_lhc = 9'd0;
                    if ({1'b0, n_lfill} >= (LFW+1)'(w_lw)) begin
                        n_state = ST_LSUM;
                        n_idx   = 9'd0;
                        n_sum   = '0;
                    end
                end else begin
                    n_lhc = w_lhc_inc;
                end
            end
            ST_LSUM: begin
                if (r_rdv) begin
                    n_sum = r_sum + 25'(r_lrd);
                end
                if (r_idx < w_lw) begin
                    n_rdv = 1'b1;
                    n_idx = r_idx + 9'd1;
                end else if (!r_rdv) begin
                    w_div_req.start    = 1'b1;
                    w_div_req.dividend = 27'(r_sum);
                    w_div_req.divisor  = w_lw;
                    w_lpop = ((LFW+1)'(r_lh) > (LFW+1)'(r_lfill)) ?
                             (LFW+1)'(r_lfill) : (LFW+1)'(r_lh);
                    n_lhead = l_wrap({1'b0, r_lhead} + (LAW+1)'(w_lpop));
                    n_lfill = r_lfill - w_lpop[LFW-1:0];
                    n_state = ST_LDIV;
                end
            end
            ST_LDIV: begin
                if (w_div_rsp.done) begin
                    n_olv   = 1'b1;
                    n_olong = w_qclamp;
                    if (r_auto) begin
                        if (w_q > {11'd0, r_crit}) begin
                            n_act = 1'b1;
                        end else if (r_act) begin
                            n_ostop = 1'b1;
                            n_act   = 1'b0;
                        end
                    end
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // result register is free: the stall above kept it so
                if (!n_ovalid) begin
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_sfill  <= '0;
            r_shead  <= '0;
            r_lfill  <= '0;
            r_lhead  <= '0;
            r_shc    <= '0;
            r_lhc    <= '0;
            r_act    <= 1'b0;
            r_rdv    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_sfill  <= n_sfill;
            r_shead  <= n_shead;
            r_lfill  <= n_lfill;
            r_lhead  <= n_lhead;
            r_shc    <= n_shc;
            r_lhc    <= n_lhc;
            r_act    <= n_act;
            r_rdv    <= n_rdv;
            r_ovalid <= n_ovalid;
        end
        r_idx    <= n_idx;
        r_sum    <= n_sum;
        r_lvl    <= n_lvl;
        r_oshort <= n_oshort;
        r_olong  <= n_olong;
        r_olv    <= n_olv;
        r_ostop  <= n_ostop;
    end

    // speech flag sampled with the result
    logic r_oact;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && !n_ovalid) begin
            r_oact <= r_act;
        end else if (r_state == ST_OUT) begin
            r_oact <= r_act;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_short_level   = r_oshort;
    assign o_long_valid    = r_olv;
    assign o_long_level    = r_olong;
    assign o_speech_active = r_oact;
    assign o_stop_event    = r_ostop;

endmodule

### sv/twld_checker.sv
// twld_checker: port level checks for the window level detector
// depends on two_stage_window_level_detector, bound below

module twld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_stall,
    input logic [15:0] o_long_level,
    input logic        o_long_valid,
    input logic        o_stop_event,
    input logic        o_speech_active
);

    // a stop event only comes with a long level
    a_stop_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_stop_event || o_long_valid))
        else $error("stop event without long level");

    // a stop event leaves the flag cleared
    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stop_event) |-> !o_speech_active)
        else $error("stop event with active flag");

    // no long level means a zero long level field
    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_long_valid) |-> (o_long_level == 16'd0))
        else $error("long level without valid");

    // a held result stalls the input
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while result held");

endmodule

bind two_stage_window_level_detector twld_checker u_twld_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_stall         (o_stall),
    .o_long_level    (o_long_level),
    .o_long_valid    (o_long_valid),
    .o_stop_event    (o_stop_event),
    .o_speech_active (o_speech_active)
);
